// ----- design/ltsg_pkg.sv -----
// Shared types, constants and helper functions for the logic trace segment generator.
// Used by the front, queue, back and top-level modules; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ltsg_pkg;

  localparam int unsigned NUM_CH     = 8;   // channel state slots
  localparam int unsigned CHANNELS   = 8;   // channels that may be drawn
  localparam int unsigned DECIMATION = 10;

  localparam int unsigned X_W     = 11;
  localparam int unsigned Y_W     = 10;
  localparam int unsigned CH_W    = 3;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned PHASE_W = 4;
  localparam int unsigned MASK_W  = 2 * NUM_CH;
  localparam int unsigned IDX_W   = $clog2(MASK_W);

  localparam logic [X_W-1:0] LEFT_EDGE  = X_W'(155);
  localparam logic [X_W-1:0] RIGHT_EDGE = X_W'(1599);
  localparam logic [X_W-1:0] X_MAX      = {X_W{1'b1}};

  localparam int unsigned STEP_ROWS = 77;
  localparam int unsigned CH_PITCH  = 90;
  localparam int unsigned ROW_BASE  = 258;
  localparam int unsigned ERASE_TOP = 181;
  localparam int unsigned ERASE_BOT = 259;
  localparam int unsigned GAP_W     = 20;
  localparam int unsigned GAP_H     = 78;

  // Division of the sample count by the decimation factor: multiply by a rounded-up
  // reciprocal, exact for every 16-bit count and factors up to 15.
  localparam int unsigned DIV_SHIFT = 20;
  localparam int unsigned DIV_M_W   = DIV_SHIFT + 1;
  localparam int unsigned PROD_W    = CNT_W + DIV_M_W;
  localparam logic [DIV_M_W-1:0] DIV_MULT =
    DIV_M_W'((64'd1 << DIV_SHIFT) / DECIMATION + 1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_FSTART = 2'd1,
    OP_FEND   = 2'd2
  } op_t;

  // One accepted item that draws something: channel state before the update,
  // and one bit per rectangle (two per channel) that the item causes.
  typedef struct packed {
    op_t                          op;
    logic [CNT_W-1:0]             dq;
    logic [NUM_CH-1:0]            bits;
    logic [MASK_W-1:0]            rect_mask;
    logic [NUM_CH-1:0][X_W-1:0]   start_x;
    logic [NUM_CH-1:0][X_W-1:0]   run_len;
    logic [NUM_CH-1:0][Y_W-1:0]   row;
    logic [NUM_CH-1:0]            level;
  } job_t;

  function automatic logic [Y_W-1:0] trace_row_reset(input logic [CH_W-1:0] k);
    trace_row_reset = Y_W'(ROW_BASE + CH_PITCH * int'(k));
  endfunction

  function automatic logic [Y_W-1:0] erase_top_row(input logic [CH_W-1:0] k);
    erase_top_row = Y_W'(ERASE_TOP + CH_PITCH * int'(k));
  endfunction

  function automatic logic [Y_W-1:0] erase_bot_row(input logic [CH_W-1:0] k);
    erase_bot_row = Y_W'(ERASE_BOT + CH_PITCH * int'(k));
  endfunction

endpackage

`default_nettype wire

// ----- design/logic_trace_segment_generator_unit.sv -----
// Top level of the logic trace segment generator: front end, job queue and back end.
// Depends on ltsg_pkg, ltsg_front, ltsg_queue and ltsg_back.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one input item per clock cycle while its job queue has room. An
// item that draws nothing (most samples, since only every tenth is used) places no
// job in the queue. An item that draws rectangles places one job in a two-entry
// queue, and the back end issues its rectangles at one per cycle while the output
// is not stalled, one rectangle per output transfer (at most sixteen per item); the
// input stalls only when the queue is full. Results come out of a register, so the
// input side keeps taking items while a finished rectangle waits for its transfer.
module logic_trace_segment_generator_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_opcode,
  input  wire logic [7:0]                  in_sample_bits,
  input  wire logic [ltsg_pkg::CNT_W-1:0]  in_sample_count,
  input  wire logic                        cfg_wr_en,
  input  wire logic [7:0]                  cfg_wr_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ltsg_pkg::X_W-1:0]         out_x_left,
  output logic [ltsg_pkg::Y_W-1:0]         out_y_top,
  output logic [ltsg_pkg::X_W-1:0]         out_x_right,
  output logic [ltsg_pkg::Y_W-1:0]         out_y_bottom,
  output logic                             out_white_fill,
  output logic [ltsg_pkg::CH_W-1:0]        out_channel_index,
  output logic                             out_last_of_run
);
  import ltsg_pkg::*;

  logic in_accept;
  logic push_valid;
  job_t push_job;
  job_t head_job;
  logic head_valid;
  logic q_full;
  logic pop;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  ltsg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_accept       (in_accept),
    .in_opcode       (in_opcode),
    .in_sample_bits  (in_sample_bits),
    .in_sample_count (in_sample_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .push_valid      (push_valid),
    .push_job        (push_job)
  );

  ltsg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .pop        (pop),
    .head_job   (head_job),
    .head_valid (head_valid),
    .full       (q_full)
  );

  ltsg_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_job          (head_job),
    .head_valid        (head_valid),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_x_left        (out_x_left),
    .out_y_top         (out_y_top),
    .out_x_right       (out_x_right),
    .out_y_bottom      (out_y_bottom),
    .out_white_fill    (out_white_fill),
    .out_channel_index (out_channel_index),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

`default_nettype wire

// ----- design/ltsg_front.sv -----
// Front end: accepts items, holds the per-channel trace state and decides which
// rectangles each item causes. Depends on ltsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ltsg_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_accept,
  input  wire logic [1:0]                in_opcode,
  input  wire logic [7:0]                in_sample_bits,
  input  wire logic [ltsg_pkg::CNT_W-1:0] in_sample_count,
  input  wire logic                      cfg_wr_en,
  input  wire logic [7:0]                cfg_wr_data,
  output logic                           push_valid,
  output ltsg_pkg::job_t                 push_job
);
  import ltsg_pkg::*;

  logic [NUM_CH-1:0]          en_mask_r;
  logic [NUM_CH-1:0][X_W-1:0] start_x_r, start_x_nxt;
  logic [NUM_CH-1:0][X_W-1:0] run_len_r, run_len_nxt;
  logic [NUM_CH-1:0][Y_W-1:0] row_r, row_nxt;
  logic [NUM_CH-1:0]          level_r, level_nxt;
  logic [PHASE_W-1:0]         phase_r, phase_nxt;

  op_t                        op;
  logic [PROD_W-1:0]          prod;
  logic [CNT_W-1:0]           dq;
  logic                       use_sample;
  logic [NUM_CH-1:0]          en;
  logic [NUM_CH-1:0][X_W:0]   end_w;
  logic [NUM_CH-1:0][X_W-1:0] end_sat;
  logic [NUM_CH-1:0][X_W-1:0] room;
  logic [MASK_W-1:0]          rect_mask;

  assign op   = op_t'(in_opcode);
  assign prod = PROD_W'(in_sample_count) * PROD_W'(DIV_MULT);
  assign dq   = prod[DIV_SHIFT +: CNT_W];
  assign use_sample = (phase_r == '0);

  always_comb begin
    start_x_nxt = start_x_r;
    run_len_nxt = run_len_r;
    row_nxt     = row_r;
    level_nxt   = level_r;
    rect_mask   = '0;
    phase_nxt   = phase_r;
    for (int k = 0; k < NUM_CH; k++) begin
      en[k]      = en_mask_r[k] && (k < CHANNELS);
      end_w[k]   = {1'b0, start_x_r[k]} + {1'b0, run_len_r[k]};
      end_sat[k] = end_w[k][X_W] ? X_MAX : end_w[k][X_W-1:0];
      room[k]    = (start_x_r[k] < RIGHT_EDGE) ? (RIGHT_EDGE - start_x_r[k]) : '0;
    end
    unique case (op)
      OP_FSTART: begin
        phase_nxt = '0;
        for (int k = 0; k < NUM_CH; k++) begin
          if (en[k] && (CNT_W'(room[k]) <= dq)) begin
            rect_mask[2*k]   = 1'b1;
            rect_mask[2*k+1] = 1'b1;
          end
        end
      end
      OP_SAMPLE: begin
        phase_nxt = (phase_r == PHASE_W'(DECIMATION - 1)) ? '0 : phase_r + 1'b1;
        for (int k = 0; k < NUM_CH; k++) begin
          if (en[k] && use_sample) begin
            if (end_w[k] >= {1'b0, RIGHT_EDGE}) begin
              // The run has reached the right edge: flush it and wrap.
              rect_mask[2*k] = 1'b1;
              start_x_nxt[k] = LEFT_EDGE;
              run_len_nxt[k] = '0;
            end else if (level_r[k] != in_sample_bits[k]) begin
              rect_mask[2*k]   = 1'b1;
              rect_mask[2*k+1] = 1'b1;
              row_nxt[k]       = level_r[k] ? row_r[k] + Y_W'(STEP_ROWS)
                                            : row_r[k] - Y_W'(STEP_ROWS);
              start_x_nxt[k]   = end_w[k][X_W-1:0] + 1'b1;
              level_nxt[k]     = ~level_r[k];
              run_len_nxt[k]   = '0;
            end else begin
              run_len_nxt[k] = run_len_r[k] + 1'b1;
            end
          end
        end
      end
      OP_FEND: begin
        phase_nxt = '0;
        for (int k = 0; k < NUM_CH; k++) begin
          if (en[k]) begin
            rect_mask[2*k]   = 1'b1;
            rect_mask[2*k+1] = ({1'b0, end_sat[k]} + (X_W+1)'(GAP_W)) < {1'b0, RIGHT_EDGE};
            start_x_nxt[k]   = end_sat[k];
            run_len_nxt[k]   = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_mask_r <= '1;
      phase_r   <= '0;
      for (int k = 0; k < NUM_CH; k++) begin
        start_x_r[k] <= LEFT_EDGE;
        run_len_r[k] <= '0;
        row_r[k]     <= trace_row_reset(CH_W'(k));
        level_r[k]   <= 1'b0;
      end
    end else begin
      if (cfg_wr_en) begin
        en_mask_r <= cfg_wr_data[NUM_CH-1:0];
      end
      if (in_accept) begin
        start_x_r <= start_x_nxt;
        run_len_r <= run_len_nxt;
        row_r     <= row_nxt;
        level_r   <= level_nxt;
        phase_r   <= phase_nxt;
      end
    end
  end

  assign push_valid         = in_accept && (rect_mask != '0);
  assign push_job.op        = op;
  assign push_job.dq        = dq;
  assign push_job.bits      = in_sample_bits[NUM_CH-1:0];
  assign push_job.rect_mask = rect_mask;
  assign push_job.start_x   = start_x_r;
  assign push_job.run_len   = run_len_r;
  assign push_job.row       = row_r;
  assign push_job.level     = level_r;

endmodule

`default_nettype wire

// ----- design/ltsg_queue.sv -----
// Short job queue between the front and back ends.
// Depends on ltsg_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module ltsg_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  input  wire ltsg_pkg::job_t push_job,
  input  wire logic           pop,
  output ltsg_pkg::job_t      head_job,
  output logic                head_valid,
  output logic                full
);
  import ltsg_pkg::*;

  job_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign head_job   = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_valid, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ----- design/ltsg_back.sv -----
// Back end: walks the rectangles of one job, one per cycle while the output is not stalled, into the output register.
// Depends on ltsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ltsg_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ltsg_pkg::job_t              head_job,
  input  wire logic                        head_valid,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ltsg_pkg::X_W-1:0]         out_x_left,
  output logic [ltsg_pkg::Y_W-1:0]         out_y_top,
  output logic [ltsg_pkg::X_W-1:0]         out_x_right,
  output logic [ltsg_pkg::Y_W-1:0]         out_y_bottom,
  output logic                             out_white_fill,
  output logic [ltsg_pkg::CH_W-1:0]        out_channel_index,
  output logic                             out_last_of_run
);
  import ltsg_pkg::*;

  job_t              cur_r, cur_nxt;
  logic [MASK_W-1:0] rem_r, rem_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [X_W-1:0]    x_left_r, x_right_r;
  logic [Y_W-1:0]    y_top_r, y_bottom_r;
  logic              white_r, last_r;
  logic [CH_W-1:0]   ch_r;

  logic [IDX_W-1:0]  idx;
  logic [CH_W-1:0]   ch;
  logic              sub;
  logic [MASK_W-1:0] rem_after;
  logic              advance;

  logic [X_W-1:0]    s, l, room, end_sat, xl, xr;
  logic [Y_W-1:0]    r, yt, yb, y_low;
  logic              lv;
  logic [X_W:0]      end_w;
  logic [CNT_W:0]    erase_right;

  // Lowest pending rectangle goes first: channel order, run before edge.
  always_comb begin
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  assign ch        = idx[IDX_W-1:1];
  assign sub       = idx[0];
  assign rem_after = rem_r & ~(MASK_W'(1) << idx);
  assign advance   = (rem_r != '0) && (!out_valid_r || !out_stall);
  assign pop       = head_valid && ((rem_r == '0) || (advance && (rem_after == '0)));

  always_comb begin
    s       = cur_r.start_x[ch];
    l       = cur_r.run_len[ch];
    r       = cur_r.row[ch];
    lv      = cur_r.level[ch];
    end_w   = {1'b0, s} + {1'b0, l};
    end_sat = end_w[X_W] ? X_MAX : end_w[X_W-1:0];
    room    = (s < RIGHT_EDGE) ? (RIGHT_EDGE - s) : '0;
    y_low   = lv ? r : r - Y_W'(STEP_ROWS);
    erase_right = (CNT_W+1)'(LEFT_EDGE) + (CNT_W+1)'(cur_r.dq) - (CNT_W+1)'(room);
    xl = s;
    xr = end_w[X_W-1:0];
    yt = r;
    yb = r + 1'b1;
    unique case (cur_r.op)
      OP_FSTART: begin
        yt = erase_top_row(ch);
        yb = erase_bot_row(ch);
        if (!sub) begin
          xr = s + room;
        end else begin
          xl = LEFT_EDGE;
          xr = (erase_right > (CNT_W+1)'(RIGHT_EDGE)) ? RIGHT_EDGE
                                                      : erase_right[X_W-1:0];
        end
      end
      OP_SAMPLE: begin
        if (end_w >= {1'b0, RIGHT_EDGE}) begin
          xr = RIGHT_EDGE;
        end else if (sub) begin
          // Vertical edge at the end column.
          xl = end_w[X_W-1:0];
          yt = y_low;
          yb = y_low + Y_W'(STEP_ROWS);
        end
      end
      OP_FEND: begin
        if (sub) begin
          // White cursor gap after the flushed run.
          xl = end_sat;
          xr = end_sat + X_W'(GAP_W);
          yt = y_low;
          yb = y_low + Y_W'(GAP_H);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cur_nxt = pop ? head_job : cur_r;
    if (pop) begin
      rem_nxt = head_job.rect_mask;
    end else if (advance) begin
      rem_nxt = rem_after;
    end else begin
      rem_nxt = rem_r;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (advance) begin
      x_left_r   <= xl;
      y_top_r    <= yt;
      x_right_r  <= xr;
      y_bottom_r <= yb;
      white_r    <= (cur_r.op == OP_FSTART) || ((cur_r.op == OP_FEND) && sub);
      ch_r       <= ch;
      last_r     <= (rem_after == '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_x_left        = x_left_r;
  assign out_y_top         = y_top_r;
  assign out_x_right       = x_right_r;
  assign out_y_bottom      = y_bottom_r;
  assign out_white_fill    = white_r;
  assign out_channel_index = ch_r;
  assign out_last_of_run   = last_r;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the logic trace segment generator top level.
// Depends on ltsg_pkg and logic_trace_segment_generator_unit; predicts every rectangle.
`timescale 1ns / 1ps

module testbench;
  import ltsg_pkg::*;

  localparam int unsigned TRACE_LEFT    = 155;
  localparam int unsigned TRACE_RIGHT   = 1599;
  localparam int unsigned X_SATURATE    = 2047;
  localparam int unsigned EDGE_ROWS     = 77;
  localparam int unsigned ROW_PITCH     = 90;
  localparam int unsigned TRACE_ROW0    = 258;
  localparam int unsigned ERASE_ROW_TOP = 181;
  localparam int unsigned ERASE_ROW_BOT = 259;
  localparam int unsigned CURSOR_W      = 20;
  localparam int unsigned CURSOR_H      = 78;
  localparam int unsigned ROW_SPAN      = 1024;

  localparam logic [1:0]  OP_RESERVED   = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASE_ITEMS   = 18;

  typedef struct packed {
    logic [X_W-1:0]  x_left;
    logic [Y_W-1:0]  y_top;
    logic [X_W-1:0]  x_right;
    logic [Y_W-1:0]  y_bottom;
    logic            white_fill;
    logic [CH_W-1:0] channel_index;
    logic            last_of_run;
  } rect_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_opcode;
  logic [7:0]       in_sample_bits;
  logic [CNT_W-1:0] in_sample_count;
  logic             cfg_wr_en;
  logic [7:0]       cfg_wr_data;
  logic             out_valid;
  logic             out_stall;
  logic [X_W-1:0]   out_x_left;
  logic [Y_W-1:0]   out_y_top;
  logic [X_W-1:0]   out_x_right;
  logic [Y_W-1:0]   out_y_bottom;
  logic             out_white_fill;
  logic [CH_W-1:0]  out_channel_index;
  logic             out_last_of_run;

  // Predicted channel state and register copy.
  logic [X_W-1:0]     seg_start  [NUM_CH];
  logic [X_W-1:0]     run_len    [NUM_CH];
  logic [Y_W-1:0]     trace_row  [NUM_CH];
  logic               trace_high [NUM_CH];
  logic [PHASE_W-1:0] decim_phase;
  logic [7:0]         enable_mask;

  rect_t       expected_draws [$];
  rect_t       staged_rect;
  bit          rect_staged;
  rect_t       oldest_draw;
  int unsigned mismatch_count;
  int unsigned sent_items;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned long_hold;

  logic_trace_segment_generator_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_sample_bits    (in_sample_bits),
    .in_sample_count   (in_sample_count),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_x_left        (out_x_left),
    .out_y_top         (out_y_top),
    .out_x_right       (out_x_right),
    .out_y_bottom      (out_y_bottom),
    .out_white_fill    (out_white_fill),
    .out_channel_index (out_channel_index),
    .out_last_of_run   (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // The previous rectangle is only released once we know it is not the last one.
  function automatic void stage_rect(input int unsigned xl, input int unsigned yt,
                                     input int unsigned xr, input int unsigned yb,
                                     input bit white, input int unsigned ch);
    if (rect_staged) expected_draws.push_back(staged_rect);
    staged_rect.x_left        = X_W'(xl);
    staged_rect.y_top         = Y_W'(yt);
    staged_rect.x_right       = X_W'(xr);
    staged_rect.y_bottom      = Y_W'(yb);
    staged_rect.white_fill    = white;
    staged_rect.channel_index = CH_W'(ch);
    staged_rect.last_of_run   = 1'b0;
    rect_staged = 1'b1;
  endfunction

  function automatic void predict_draws(input logic [1:0] op, input logic [7:0] bits,
                                        input logic [CNT_W-1:0] cnt);
    int unsigned d, room, s, e, r, xr, ya, yb, y;
    bit          used;
    if (op == OP_FSTART) begin
      d = cnt / DECIMATION;
      for (int k = 0; k < CHANNELS; k++) begin
        s = seg_start[k];
        room = (s < TRACE_RIGHT) ? TRACE_RIGHT - s : 0;
        if (enable_mask[k] && room <= d) begin
          xr = TRACE_LEFT + d - room;
          if (xr > TRACE_RIGHT) xr = TRACE_RIGHT;
          stage_rect(s, ERASE_ROW_TOP + ROW_PITCH * k, s + room,
                     ERASE_ROW_BOT + ROW_PITCH * k, 1'b1, k);
          stage_rect(TRACE_LEFT, ERASE_ROW_TOP + ROW_PITCH * k, xr,
                     ERASE_ROW_BOT + ROW_PITCH * k, 1'b1, k);
        end
      end
      decim_phase = '0;
    end else if (op == OP_SAMPLE) begin
      used = (decim_phase == 0);
      decim_phase = PHASE_W'((decim_phase + 1) % DECIMATION);
      if (used) begin
        for (int k = 0; k < CHANNELS; k++) begin
          s = seg_start[k];
          e = s + run_len[k];
          r = trace_row[k];
          if (enable_mask[k]) begin
            if (e >= TRACE_RIGHT) begin
              // Run hit the right edge: flush it and wrap, ignoring the bit.
              stage_rect(s, r, TRACE_RIGHT, r + 1, 1'b0, k);
              seg_start[k] = X_W'(TRACE_LEFT);
              run_len[k]   = '0;
            end else if (trace_high[k] != bits[k]) begin
              stage_rect(s, r, e, r + 1, 1'b0, k);
              if (trace_high[k]) begin
                ya = r;
                yb = (r + EDGE_ROWS) % ROW_SPAN;
                trace_row[k] = Y_W'(yb);
              end else begin
                ya = (r + ROW_SPAN - EDGE_ROWS) % ROW_SPAN;
                yb = r;
                trace_row[k] = Y_W'(ya);
              end
              stage_rect(e, ya, e, yb, 1'b0, k);
              seg_start[k]  = X_W'(e + 1);
              run_len[k]    = '0;
              trace_high[k] = ~trace_high[k];
            end else begin
              run_len[k] = run_len[k] + 1'b1;
            end
          end
        end
      end
    end else if (op == OP_FEND) begin
      for (int k = 0; k < CHANNELS; k++) begin
        s = seg_start[k];
        e = s + run_len[k];
        r = trace_row[k];
        if (enable_mask[k]) begin
          stage_rect(s, r, e, r + 1, 1'b0, k);
          if (e > X_SATURATE) e = X_SATURATE;
          seg_start[k] = X_W'(e);
          run_len[k]   = '0;
          if (e + CURSOR_W < TRACE_RIGHT) begin
            y = trace_high[k] ? r : (r + ROW_SPAN - EDGE_ROWS) % ROW_SPAN;
            stage_rect(e, y, e + CURSOR_W, y + CURSOR_H, 1'b1, k);
          end
        end
      end
      decim_phase = '0;
    end
    if (rect_staged) begin
      staged_rect.last_of_run = 1'b1;
      expected_draws.push_back(staged_rect);
      rect_staged = 1'b0;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_draws.size() == 0) begin
        $display("%0t ns: unexpected rectangle, expected none, actual x %0d..%0d y %0d..%0d ch %0d",
                 $time, out_x_left, out_x_right, out_y_top, out_y_bottom, out_channel_index);
        mismatch_count++;
      end else begin
        oldest_draw = expected_draws.pop_front();
        check_field("x_left", oldest_draw.x_left, out_x_left);
        check_field("y_top", oldest_draw.y_top, out_y_top);
        check_field("x_right", oldest_draw.x_right, out_x_right);
        check_field("y_bottom", oldest_draw.y_bottom, out_y_bottom);
        check_field("white_fill", oldest_draw.white_fill, out_white_fill);
        check_field("channel_index", oldest_draw.channel_index, out_channel_index);
        check_field("last_of_run", oldest_draw.last_of_run, out_last_of_run);
      end
    end
  end

  // Draw sink: stalls a random number of cycles before each transfer, or for a
  // long stretch when a test asks for one.
  initial begin
    int unsigned wait_n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold != 0) begin
        wait_n    = long_hold;
        long_hold = 0;
      end else begin
        wait_n = rx_idle_on ? $urandom_range(0, 17) : 0;
      end
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] bits,
                           input logic [CNT_W-1:0] cnt);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 17) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_sample_bits  <= bits;
    in_sample_count <= cnt;
    do @(posedge clk); while (in_stall);
    predict_draws(op, bits, cnt);
    sent_items++;
  endtask

  // Stops offering and waits until every predicted rectangle has been taken.
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_draws.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_enable_mask(input logic [7:0] mask);
    settle_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    enable_mask = mask;
  endtask

  task automatic test_erase_threshold();
    send_item(OP_FSTART, 8'h00, 16'd0);
    send_item(OP_FSTART, 8'hFF, 16'd14439);
    send_item(OP_FSTART, 8'h00, 16'd14440);
    send_item(OP_FSTART, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_level_changes();
    send_item(OP_FSTART, 8'h00, 16'd0);
    send_item(OP_SAMPLE, 8'hFF, 16'h0000);
    send_item(OP_SAMPLE, 8'h00, 16'hFFFF);
    send_item(OP_FSTART, 8'h00, 16'd0);
    send_item(OP_SAMPLE, 8'h00, 16'h0000);
    send_item(OP_FSTART, 8'h00, 16'd0);
    send_item(OP_SAMPLE, 8'hA5, 16'h0000);
    send_item(OP_FEND, 8'h00, 16'h0000);
    send_item(OP_RESERVED, 8'hFF, 16'hFFFF);
    send_item(OP_RESERVED, 8'h00, 16'h0000);
    send_item(OP_FEND, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_enable_mask();
    write_enable_mask(8'h00);
    send_item(OP_FSTART, 8'h00, 16'hFFFF);
    send_item(OP_SAMPLE, 8'hFF, 16'h0000);
    send_item(OP_FEND, 8'h00, 16'h0000);
    write_enable_mask(8'h80);
    send_item(OP_FSTART, 8'h00, 16'd0);
    send_item(OP_SAMPLE, 8'h00, 16'h0000);
    send_item(OP_FEND, 8'h00, 16'h0000);
    write_enable_mask(8'h01);
    send_item(OP_FSTART, 8'h00, 16'hFFFF);
    send_item(OP_SAMPLE, 8'h5A, 16'h0000);
    send_item(OP_FEND, 8'h00, 16'h0000);
    write_enable_mask(8'hFF);
  endtask

  // The sink holds off while erase bursts keep coming, so the job queue fills.
  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    long_hold  = HOLD_CYCLES;
    repeat (4) begin
      send_item(OP_FSTART, 8'h00, 16'hFFFF);
      send_item(OP_SAMPLE, 8'($urandom), 16'h0000);
    end
    send_item(OP_FEND, 8'h00, 16'h0000);
    tx_idle_on = 1'b1;
  endtask

  task automatic random_frame();
    int unsigned pick, n;
    logic [7:0]  bits;
    pick = $urandom_range(0, 9);
    bits = 8'($urandom);
    if (pick == 0) begin
      send_item(2'($urandom_range(0, 3)), 8'($urandom), CNT_W'($urandom));
    end else begin
      // Pick 1 drops the frame start and pick 2 the frame end.
      if (pick != 1)
        send_item(OP_FSTART, 8'($urandom),
                  $urandom_range(0, 1) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 3000)));
      n = $urandom_range(1, 16);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) bits ^= 8'(1 << $urandom_range(0, 7));
        send_item(OP_SAMPLE, bits, CNT_W'($urandom));
      end
      if (pick != 2) send_item(OP_FEND, 8'($urandom), CNT_W'($urandom));
    end
  endtask

  task automatic test_random_frames();
    int unsigned goal;
    for (int p = 0; p < 5; p++) begin
      write_enable_mask((p == 0) ? 8'hFF : 8'($urandom_range(1, 254)));
      tx_idle_on = (p != 1);
      rx_idle_on = (p != 2);
      goal = sent_items + PHASE_ITEMS;
      while (sent_items < goal) random_frame();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = OP_SAMPLE;
    in_sample_bits  = '0;
    in_sample_count = '0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    long_hold       = 0;
    mismatch_count  = 0;
    sent_items      = 0;
    rect_staged     = 1'b0;
    enable_mask     = 8'hFF;
    decim_phase     = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      seg_start[k]  = X_W'(TRACE_LEFT);
      run_len[k]    = '0;
      trace_row[k]  = Y_W'(TRACE_ROW0 + ROW_PITCH * k);
      trace_high[k] = 1'b0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_erase_threshold();
    test_level_changes();
    test_enable_mask();
    test_output_backpressure();
    test_random_frames();
    settle_idle();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
